// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the transport engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

// ----- sv/artx_pkg.sv -----
// ----------------------------------------------------------------------------
// artx_pkg
// Types, codes and sizes shared by the transport engine modules.
// ----------------------------------------------------------------------------
package artx_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int TABLE_DEPTH = 8;
    localparam int ID_BITS     = 16;
    localparam int PEER_BITS   = 8;
    localparam int MAX_RESULTS = 8;
    localparam int TIME_W      = 32;
    localparam int TMO_W       = 8;

    localparam int QA_W = $clog2(QUEUE_DEPTH);
    localparam int TA_W = $clog2(TABLE_DEPTH);
    localparam int QC_W = QA_W + 1;
    localparam int TC_W = TA_W + 1;
    localparam int IX_W = (QC_W > TC_W) ? QC_W : TC_W;
    localparam int RA_W = $clog2(MAX_RESULTS);
    localparam int RC_W = RA_W + 1;

    localparam logic [1:0] CMD_SEND = 2'd0;
    localparam logic [1:0] CMD_RECV = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;
    localparam logic [1:0] KIND_RETX = 2'd2;

    localparam logic [2:0] EV_QUEUED    = 3'd0;
    localparam logic [2:0] EV_REJECTED  = 3'd1;
    localparam logic [2:0] EV_DELIVERED = 3'd2;
    localparam logic [2:0] EV_DUPLICATE = 3'd3;
    localparam logic [2:0] EV_ACK_MATCH = 3'd4;
    localparam logic [2:0] EV_ACK_MISS  = 3'd5;
    localparam logic [2:0] EV_TRANSMIT  = 3'd6;
    localparam logic [2:0] EV_IDLE      = 3'd7;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [ID_BITS-1:0]   msg_id;
        logic [1:0]           msg_kind;
        logic [PEER_BITS-1:0] peer;
        logic [TIME_W-1:0]    now_seconds;
    } in_item_t;

    typedef struct packed {
        logic [2:0]           event_res;
        logic [ID_BITS-1:0]   out_id;
        logic [1:0]           out_kind;
        logic [PEER_BITS-1:0] out_peer;
        logic                 ack_queued;
        logic                 all_done;
        logic                 last;
    } out_item_t;

    typedef struct packed {
        logic [2:0]           event_res;
        logic [ID_BITS-1:0]   out_id;
        logic [1:0]           out_kind;
        logic [PEER_BITS-1:0] out_peer;
        logic                 ack_queued;
    } rec_t;

    typedef struct packed {
        logic push;
        rec_t rec;
        logic start;
        logic done;
    } rbuf_ctl_t;

    typedef struct packed {
        logic            busy;
        logic [RC_W-1:0] count;
    } rbuf_stat_t;

endpackage

// ----- sv/ack_retransmit_transport_engine_core.sv -----
// ----------------------------------------------------------------------------
// ack_retransmit_transport_engine_core
// Positive-acknowledgement transport engine with retransmission on IDs.
// ----------------------------------------------------------------------------
// One item is handled at a time. The sequencer visits one table entry per
// cycle: an ACK walks the pending entries, a received data message the
// seen entries, and a tick the pending entries and then, for each entry
// sent, the queue to find the lowest ID and the entries behind it.
// The results are then presented one per cycle while the output is not
// stalled, and the next item is taken once the last result has left.
`include "assert_macros.svh"

module ack_retransmit_transport_engine_core
    import artx_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [TMO_W-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_item,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_item
);

    rbuf_ctl_t  ctl;
    rbuf_stat_t stat;

    artx_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .stat      (stat),
        .ctl       (ctl)
    );

    artx_rbuf u_rbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

// ----- sv/artx_rbuf.sv -----
// ----------------------------------------------------------------------------
// artx_rbuf
// Collects the results of one item and then presents them on the output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module artx_rbuf
    import artx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  rbuf_ctl_t  ctl,
    output rbuf_stat_t stat,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_item
);

    rec_t            buf_reg [MAX_RESULTS];
    logic [RC_W-1:0] count_reg, count_next;
    logic [RA_W-1:0] rptr_reg, rptr_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic            is_last;
    logic            take;
    rec_t            cur;

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            buf_reg[count_reg[RA_W-1:0]] <= ctl.rec;
        end
    end

    assign cur     = buf_reg[rptr_reg];
    assign is_last = ({1'b0, rptr_reg} == count_reg - RC_W'(1));
    assign take    = busy_reg && !out_stall;

    always_comb
    begin
        count_next = count_reg;
        rptr_next  = rptr_reg;
        busy_next  = busy_reg;
        done_next  = done_reg;
        if (ctl.push)
        begin
            count_next = count_reg + RC_W'(1);
        end
        if (ctl.start)
        begin
            busy_next = 1'b1;
            done_next = ctl.done;
            rptr_next = '0;
        end
        else if (take)
        begin
            if (is_last)
            begin
                busy_next  = 1'b0;
                count_next = '0;
                rptr_next  = '0;
            end
            else
            begin
                rptr_next = rptr_reg + RA_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rptr_reg  <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            rptr_reg  <= rptr_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign out_valid           = busy_reg;
    assign out_item.event_res  = cur.event_res;
    assign out_item.out_id     = cur.out_id;
    assign out_item.out_kind   = cur.out_kind;
    assign out_item.out_peer   = cur.out_peer;
    assign out_item.ack_queued = cur.ack_queued;
    assign out_item.all_done   = done_reg;
    assign out_item.last       = is_last;
    assign stat.busy           = busy_reg;
    assign stat.count          = count_reg;

    `ASSERT_CLK(a_last_ends, clk, rst_n, (take && is_last) |=> !busy_reg)
    `ASSERT_NEVER(a_push_busy, clk, rst_n, ctl.push && busy_reg)
    `ASSERT_CLK(a_nonempty, clk, rst_n, busy_reg |-> (count_reg != '0))

endmodule

// ----- sv/artx_engine.sv -----
// ----------------------------------------------------------------------------
// artx_engine
// Queue, pending table and seen ring, walked one entry per cycle by a
// small sequencer built around compare and subtract logic.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module artx_engine
    import artx_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [TMO_W-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_item,
    input  rbuf_stat_t       stat,
    output rbuf_ctl_t        ctl
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DISP      = 4'd1;
    localparam logic [3:0] S_ACK_SCAN  = 4'd2;
    localparam logic [3:0] S_ACK_SHIFT = 4'd3;
    localparam logic [3:0] S_SEEN_SCAN = 4'd4;
    localparam logic [3:0] S_TO_SCAN   = 4'd5;
    localparam logic [3:0] S_DRAIN     = 4'd6;
    localparam logic [3:0] S_MIN_SCAN  = 4'd7;
    localparam logic [3:0] S_EMIT      = 4'd8;
    localparam logic [3:0] S_Q_SHIFT   = 4'd9;
    localparam logic [3:0] S_FIN       = 4'd10;

    logic [ID_BITS-1:0]   q_id_reg   [QUEUE_DEPTH];
    logic [1:0]           q_kind_reg [QUEUE_DEPTH];
    logic [PEER_BITS-1:0] q_peer_reg [QUEUE_DEPTH];
    logic [ID_BITS-1:0]   p_id_reg   [TABLE_DEPTH];
    logic [PEER_BITS-1:0] p_peer_reg [TABLE_DEPTH];
    logic [TIME_W-1:0]    p_time_reg [TABLE_DEPTH];
    logic [ID_BITS-1:0]   seen_reg   [TABLE_DEPTH];

    logic [3:0]         state_reg, state_next;
    in_item_t           cur_reg;
    logic [IX_W-1:0]    idx_reg, idx_next;
    logic [QA_W-1:0]    best_reg, best_next;
    logic [ID_BITS-1:0] bestid_reg, bestid_next;
    logic [QC_W-1:0]    qcnt_reg, qcnt_next;
    logic [TC_W-1:0]    pcnt_reg, pcnt_next;
    logic [TA_W-1:0]    spos_reg, spos_next;
    logic [TC_W-1:0]    sfill_reg, sfill_next;
    logic [ID_BITS-1:0] nid_reg, nid_next;
    logic [TMO_W-1:0]   tmo_reg;

    logic [IX_W-1:0]      idx_p1, rd_ix;
    logic [ID_BITS-1:0]   q_rid;
    logic [1:0]           q_rkind;
    logic [PEER_BITS-1:0] q_rpeer;
    logic [ID_BITS-1:0]   p_rid;
    logic [PEER_BITS-1:0] p_rpeer;
    logic [TIME_W-1:0]    p_rtime;
    logic [TIME_W-1:0]    age;
    logic                 q_full;

    logic                 q_we;
    logic [QA_W-1:0]      q_wa;
    logic [ID_BITS-1:0]   q_wid;
    logic [1:0]           q_wkind;
    logic [PEER_BITS-1:0] q_wpeer;
    logic                 p_we;
    logic [TA_W-1:0]      p_wa;
    logic [ID_BITS-1:0]   p_wid;
    logic [PEER_BITS-1:0] p_wpeer;
    logic [TIME_W-1:0]    p_wtime;
    logic                 s_we;
    logic                 accept;

    assign accept   = in_valid && !in_stall;
    assign in_stall = !((state_reg == S_IDLE) && !stat.busy);
    assign idx_p1   = idx_reg + IX_W'(1);
    assign rd_ix    = ((state_reg == S_Q_SHIFT) || (state_reg == S_ACK_SHIFT)) ?
                      idx_p1 : idx_reg;
    assign q_rid    = q_id_reg[rd_ix[QA_W-1:0]];
    assign q_rkind  = q_kind_reg[rd_ix[QA_W-1:0]];
    assign q_rpeer  = q_peer_reg[rd_ix[QA_W-1:0]];
    assign p_rid    = p_id_reg[rd_ix[TA_W-1:0]];
    assign p_rpeer  = p_peer_reg[rd_ix[TA_W-1:0]];
    assign p_rtime  = p_time_reg[rd_ix[TA_W-1:0]];
    assign age      = cur_reg.now_seconds - p_rtime;
    assign q_full   = (qcnt_reg == QC_W'(QUEUE_DEPTH));

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        best_next   = best_reg;
        bestid_next = bestid_reg;
        qcnt_next   = qcnt_reg;
        pcnt_next   = pcnt_reg;
        spos_next   = spos_reg;
        sfill_next  = sfill_reg;
        nid_next    = nid_reg;
        q_we        = 1'b0;
        q_wa        = qcnt_reg[QA_W-1:0];
        q_wid       = cur_reg.msg_id;
        q_wkind     = KIND_ACK;
        q_wpeer     = cur_reg.peer;
        p_we        = 1'b0;
        p_wa        = idx_reg[TA_W-1:0];
        p_wid       = p_rid;
        p_wpeer     = p_rpeer;
        p_wtime     = p_rtime;
        s_we        = 1'b0;
        ctl         = '0;
        ctl.done    = (qcnt_reg == '0) && (pcnt_reg == '0);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                idx_next = '0;
                priority case (cur_reg.cmd)
                    CMD_SEND:
                    begin
                        ctl.push          = 1'b1;
                        ctl.rec.out_peer  = cur_reg.peer;
                        if (q_full)
                        begin
                            ctl.rec.event_res = EV_REJECTED;
                        end
                        else
                        begin
                            ctl.rec.event_res = EV_QUEUED;
                            ctl.rec.out_id    = nid_reg;
                            q_we              = 1'b1;
                            q_wid             = nid_reg;
                            q_wkind           = KIND_DATA;
                            qcnt_next         = qcnt_reg + QC_W'(1);
                            nid_next          = nid_reg + ID_BITS'(1);
                        end
                        state_next = S_FIN;
                    end
                    CMD_RECV:
                    begin
                        state_next = (cur_reg.msg_kind == KIND_ACK) ? S_ACK_SCAN :
                                     S_SEEN_SCAN;
                    end
                    CMD_TICK:
                    begin
                        state_next = S_TO_SCAN;
                    end
                    default:
                    begin
                        ctl.push          = 1'b1;
                        ctl.rec.event_res = EV_IDLE;
                        state_next        = S_FIN;
                    end
                endcase
            end
            S_ACK_SCAN:
            begin
                if (idx_reg >= IX_W'(pcnt_reg))
                begin
                    ctl.push          = 1'b1;
                    ctl.rec.event_res = EV_ACK_MISS;
                    ctl.rec.out_id    = cur_reg.msg_id;
                    ctl.rec.out_peer  = cur_reg.peer;
                    state_next        = S_FIN;
                end
                else if (p_rid == cur_reg.msg_id)
                begin
                    state_next = S_ACK_SHIFT;
                end
                else
                begin
                    idx_next = idx_p1;
                end
            end
            S_ACK_SHIFT:
            begin
                if (idx_p1 < IX_W'(pcnt_reg))
                begin
                    p_we     = 1'b1;
                    idx_next = idx_p1;
                end
                else
                begin
                    pcnt_next         = pcnt_reg - TC_W'(1);
                    ctl.push          = 1'b1;
                    ctl.rec.event_res = EV_ACK_MATCH;
                    ctl.rec.out_id    = cur_reg.msg_id;
                    ctl.rec.out_peer  = cur_reg.peer;
                    state_next        = S_FIN;
                end
            end
            S_SEEN_SCAN:
            begin
                if ((idx_reg >= IX_W'(sfill_reg)) ||
                    (seen_reg[idx_reg[TA_W-1:0]] == cur_reg.msg_id))
                begin
                    ctl.push          = 1'b1;
                    ctl.rec.out_id    = cur_reg.msg_id;
                    ctl.rec.out_peer  = cur_reg.peer;
                    ctl.rec.event_res = EV_DUPLICATE;
                    if (idx_reg >= IX_W'(sfill_reg))
                    begin
                        ctl.rec.event_res = EV_DELIVERED;
                        s_we              = 1'b1;
                        spos_next = (spos_reg == TA_W'(TABLE_DEPTH - 1)) ? '0 :
                                    spos_reg + TA_W'(1);
                        if (sfill_reg != TC_W'(TABLE_DEPTH))
                        begin
                            sfill_next = sfill_reg + TC_W'(1);
                        end
                    end
                    if (!q_full)
                    begin
                        q_we               = 1'b1;
                        qcnt_next          = qcnt_reg + QC_W'(1);
                        ctl.rec.ack_queued = 1'b1;
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    idx_next = idx_p1;
                end
            end
            S_TO_SCAN:
            begin
                if ((idx_reg >= IX_W'(pcnt_reg)) || q_full)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    if (age > TIME_W'(tmo_reg))
                    begin
                        p_we      = 1'b1;
                        p_wtime   = cur_reg.now_seconds;
                        q_we      = 1'b1;
                        q_wid     = p_rid;
                        q_wkind   = KIND_RETX;
                        q_wpeer   = p_rpeer;
                        qcnt_next = qcnt_reg + QC_W'(1);
                    end
                    idx_next = idx_p1;
                end
            end
            S_DRAIN:
            begin
                if ((pcnt_reg < TC_W'(TABLE_DEPTH)) && (qcnt_reg != '0) &&
                    (stat.count < RC_W'(MAX_RESULTS)))
                begin
                    idx_next    = '0;
                    best_next   = '0;
                    bestid_next = '1;
                    state_next  = S_MIN_SCAN;
                end
                else
                begin
                    if (stat.count == '0)
                    begin
                        ctl.push          = 1'b1;
                        ctl.rec.event_res = EV_IDLE;
                    end
                    state_next = S_FIN;
                end
            end
            S_MIN_SCAN:
            begin
                if (idx_reg >= IX_W'(qcnt_reg))
                begin
                    idx_next   = IX_W'(best_reg);
                    state_next = S_EMIT;
                end
                else
                begin
                    if (q_rid < bestid_reg)
                    begin
                        best_next   = idx_reg[QA_W-1:0];
                        bestid_next = q_rid;
                    end
                    idx_next = idx_p1;
                end
            end
            S_EMIT:
            begin
                ctl.push          = 1'b1;
                ctl.rec.event_res = EV_TRANSMIT;
                ctl.rec.out_id    = q_rid;
                ctl.rec.out_kind  = q_rkind;
                ctl.rec.out_peer  = q_rpeer;
                if (q_rkind == KIND_DATA)
                begin
                    p_we      = 1'b1;
                    p_wa      = pcnt_reg[TA_W-1:0];
                    p_wid     = q_rid;
                    p_wpeer   = q_rpeer;
                    p_wtime   = cur_reg.now_seconds;
                    pcnt_next = pcnt_reg + TC_W'(1);
                end
                state_next = S_Q_SHIFT;
            end
            S_Q_SHIFT:
            begin
                if (idx_p1 < IX_W'(qcnt_reg))
                begin
                    q_we     = 1'b1;
                    q_wa     = idx_reg[QA_W-1:0];
                    q_wid    = q_rid;
                    q_wkind  = q_rkind;
                    q_wpeer  = q_rpeer;
                    idx_next = idx_p1;
                end
                else
                begin
                    qcnt_next  = qcnt_reg - QC_W'(1);
                    state_next = S_DRAIN;
                end
            end
            S_FIN:
            begin
                ctl.start  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg <= in_item;
        end
        if (q_we)
        begin
            q_id_reg[q_wa]   <= q_wid;
            q_kind_reg[q_wa] <= q_wkind;
            q_peer_reg[q_wa] <= q_wpeer;
        end
        if (p_we)
        begin
            p_id_reg[p_wa]   <= p_wid;
            p_peer_reg[p_wa] <= p_wpeer;
            p_time_reg[p_wa] <= p_wtime;
        end
        if (s_we)
        begin
            seen_reg[spos_reg] <= cur_reg.msg_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            best_reg   <= '0;
            bestid_reg <= '0;
            qcnt_reg   <= '0;
            pcnt_reg   <= '0;
            spos_reg   <= '0;
            sfill_reg  <= '0;
            nid_reg    <= '0;
            tmo_reg    <= TMO_W'(2);
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            best_reg   <= best_next;
            bestid_reg <= bestid_next;
            qcnt_reg   <= qcnt_next;
            pcnt_reg   <= pcnt_next;
            spos_reg   <= spos_next;
            sfill_reg  <= sfill_next;
            nid_reg    <= nid_next;
            if (cfg_we)
            begin
                tmo_reg <= cfg_wdata;
            end
        end
    end

    `ASSERT_CLK(a_accept_busy, clk, rst_n, accept |=> (state_reg == S_DISP))
    `ASSERT_CLK(a_fin_start, clk, rst_n, (state_reg == S_FIN) |=> stat.busy)
    `ASSERT_NEVER(a_q_over, clk, rst_n, q_we && q_full && (state_reg != S_Q_SHIFT))
    `ASSERT_CLK(a_p_bound, clk, rst_n, pcnt_reg <= TC_W'(TABLE_DEPTH))

endmodule
